### rtl/ngf_pkg.sv
// shared types and constants of the n-body gravity force core
// no dependencies; imported by every module of the core
`default_nettype none

package ngf_pkg;

    // field widths
    localparam int unsigned IDX_W    = 9;
    localparam int unsigned COORD_W  = 32;
    localparam int unsigned MASS_W   = 32;
    localparam int unsigned FORCE_W  = 48;
    localparam int unsigned ACTIVE_W = 10;
    localparam int unsigned GRAV_W   = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned IN_DATA_W  = 144;
    localparam int unsigned OUT_DATA_W = 144;
    localparam int unsigned MEM_W    = 4 * COORD_W;

    // datapath widths
    localparam int unsigned ACC_W  = 64;
    localparam int unsigned D_W    = 33;
    localparam int unsigned R2_W   = 66;
    localparam int unsigned RAD_W  = 68;
    localparam int unsigned ROOT_W = 34;
    localparam int unsigned REM_W  = 36;
    localparam int unsigned GMI_W  = 64;
    localparam int unsigned GM_W   = 96;
    localparam int unsigned DEN_W  = 102;
    localparam int unsigned MA_W   = 96;
    localparam int unsigned MB_W   = 34;
    localparam int unsigned PROD_W = 130;
    localparam int unsigned NUM_W  = 138;
    localparam int unsigned Q_W    = 51;

    // register reset values
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 10'd512;
    localparam logic [GRAV_W-1:0]   GRAV_RESET   = 32'h0001_0000;

    // output rails, signed Q24.24
    localparam logic signed [ACC_W-1:0] FORCE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] FORCE_MIN = 64'shFFFF_8000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_BODIES = 2'd0,
        REG_GRAVITY       = 2'd1
    } cfg_reg_t;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } item_cmd_t;

    typedef enum logic [2:0] {
        MUL_GMI = 3'd0,
        MUL_SQ  = 3'd1,
        MUL_RR  = 3'd2,
        MUL_RRR = 3'd3,
        MUL_GM  = 3'd4,
        MUL_NUM = 3'd5
    } mul_op_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TGT_RD,
        ST_TGT_LD,
        ST_GMI_GO,
        ST_GMI,
        ST_BODY_RD,
        ST_BODY_LD,
        ST_BODY_CHK,
        ST_SQ_GO,
        ST_SQ,
        ST_SQRT_GO,
        ST_SQRT,
        ST_RR,
        ST_RRR,
        ST_GM,
        ST_AXIS,
        ST_NUM,
        ST_DIV,
        ST_FINAL
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    clr_step;
        logic    load_wr;
        logic    item_take;
        logic    rd_target;
        logic    latch_target;
        logic    latch_gmi;
        logic    rd_body;
        logic    latch_body;
        logic    next_body;
        logic    mul_start;
        mul_op_t mul_op;
        logic    r2_add;
        logic    sqrt_start;
        logic    latch_den;
        logic    latch_gm;
        logic    axis_skip;
        logic    div_start;
        logic    acc_add;
        logic    out_load;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic in_query;
        logic in_idx_ok;
        logic body_more;
        logic d_zero;
        logic axis_d_zero;
        logic axis_last;
        logic mul_busy;
        logic mul_done;
        logic sqrt_done;
        logic div_done;
        logic out_free;
    } ctrl_stat_t;

endpackage

`default_nettype wire

### rtl/ngf_mul.sv
// shift-add multiplier, one multiplier bit per cycle
// depends on ngf_pkg for operand and product widths
`default_nettype none

module ngf_mul (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  wire  [ngf_pkg::MA_W-1:0]    a,
    input  wire  [ngf_pkg::MB_W-1:0]    b,
    output logic [ngf_pkg::PROD_W-1:0]  prod,
    output logic                        busy,
    output logic                        done
);
    import ngf_pkg::*;

    logic [PROD_W-1:0] a_reg, a_next;
    logic [PROD_W-1:0] p_reg, p_next;
    logic [MB_W-1:0]   b_reg, b_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    // one partial product per cycle, stops when the multiplier bits run out
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = PROD_W'(a);
            b_next    = b;
            p_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                p_next = p_reg + a_reg;
            end
            a_next = a_reg << 1;
            b_next = b_reg >> 1;
            if ((b_reg >> 1) == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // operand and product registers
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        p_reg <= p_next;
    end

    assign prod = p_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

### rtl/ngf_div.sv
// restoring divider, one quotient bit per cycle, quotient capped at 2^50
// depends on ngf_pkg for numerator, divisor and quotient widths
`default_nettype none

module ngf_div (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  wire  [ngf_pkg::NUM_W-1:0]   num,
    input  wire  [ngf_pkg::DEN_W-1:0]   den,
    output logic [ngf_pkg::Q_W-1:0]     quo,
    output logic                        clip,
    output logic                        done
);
    import ngf_pkg::*;

    localparam int unsigned DS_W  = DEN_W + Q_W;
    localparam int unsigned CNT_W = $clog2(Q_W + 1);
    localparam logic [Q_W-1:0] Q_CAP = Q_W'(1) << (Q_W - 1);

    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [DS_W-2:0]   ds_reg, ds_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              clip_reg, clip_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              over;
    logic              ge;
    logic [Q_W-1:0]    q_step;

    // quotient would not fit in 51 bits
    assign over   = DS_W'(num) >= {den, Q_W'(0)};
    assign ge     = (DS_W - 1)'(rem_reg) >= ds_reg;
    assign q_step = {q_reg[Q_W-2:0], ge};

    always_comb
    begin
        rem_next  = rem_reg;
        ds_next   = ds_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        clip_next = clip_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            ds_next   = {den, (Q_W - 1)'(0)};
            q_next    = '0;
            cnt_next  = CNT_W'(Q_W);
            clip_next = over;
            if (over)
            begin
                q_next    = Q_CAP;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - NUM_W'(ds_reg);
            end
            ds_next  = ds_reg >> 1;
            q_next   = q_step;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (q_step > Q_CAP)
                begin
                    q_next    = Q_CAP;
                    clip_next = 1'b1;
                end
            end
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        ds_reg   <= ds_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        clip_reg <= clip_next;
    end

    assign quo  = q_reg;
    assign clip = clip_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

### rtl/ngf_ctrl.sv
// sequencer of the force core: clearing pass, loads, query walk
// depends on ngf_pkg for state, command and status types
`default_nettype none

module ngf_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  ngf_pkg::ctrl_stat_t     stat,
    output ngf_pkg::ctrl_cmd_t      cmd
);
    import ngf_pkg::*;

    ctrl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = MUL_GMI;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (!stat.in_query)
                    begin
                        cmd.load_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.item_take = 1'b1;
                        state_next = stat.in_idx_ok ? ST_TGT_RD : ST_FINAL;
                    end
                end
            end
            ST_TGT_RD:
            begin
                cmd.rd_target = 1'b1;
                state_next    = ST_TGT_LD;
            end
            ST_TGT_LD:
            begin
                cmd.latch_target = 1'b1;
                state_next       = ST_GMI_GO;
            end
            ST_GMI_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_op    = MUL_GMI;
                state_next    = ST_GMI;
            end
            ST_GMI:
            begin
                if (stat.mul_done)
                begin
                    cmd.latch_gmi = 1'b1;
                    state_next    = ST_BODY_RD;
                end
            end
            ST_BODY_RD:
            begin
                if (stat.body_more)
                begin
                    cmd.rd_body = 1'b1;
                    state_next  = ST_BODY_LD;
                end
                else
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_BODY_LD:
            begin
                cmd.latch_body = 1'b1;
                state_next     = ST_BODY_CHK;
            end
            ST_BODY_CHK:
            begin
                // coincident body adds nothing
                if (stat.d_zero)
                begin
                    cmd.next_body = 1'b1;
                    state_next    = ST_BODY_RD;
                end
                else
                begin
                    state_next = ST_SQ_GO;
                end
            end
            ST_SQ_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_op    = MUL_SQ;
                state_next    = ST_SQ;
            end
            ST_SQ:
            begin
                if (stat.mul_done)
                begin
                    cmd.r2_add = 1'b1;
                    state_next = stat.axis_last ? ST_SQRT_GO : ST_SQ_GO;
                end
            end
            ST_SQRT_GO:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (stat.sqrt_done)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MUL_RR;
                    state_next    = ST_RR;
                end
            end
            ST_RR:
            begin
                if (stat.mul_done)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MUL_RRR;
                    state_next    = ST_RRR;
                end
            end
            ST_RRR:
            begin
                if (stat.mul_done)
                begin
                    cmd.latch_den = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MUL_GM;
                    state_next    = ST_GM;
                end
            end
            ST_GM:
            begin
                if (stat.mul_done)
                begin
                    cmd.latch_gm = 1'b1;
                    state_next   = ST_AXIS;
                end
            end
            ST_AXIS:
            begin
                if (stat.axis_d_zero)
                begin
                    cmd.axis_skip = 1'b1;
                    if (stat.axis_last)
                    begin
                        cmd.next_body = 1'b1;
                        state_next    = ST_BODY_RD;
                    end
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MUL_NUM;
                    state_next    = ST_NUM;
                end
            end
            ST_NUM:
            begin
                if (stat.mul_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.acc_add = 1'b1;
                    if (stat.axis_last)
                    begin
                        cmd.next_body = 1'b1;
                        state_next    = ST_BODY_RD;
                    end
                    else
                    begin
                        state_next = ST_AXIS;
                    end
                end
            end
            ST_FINAL:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/ngf_datapath.sv
// datapath of the force core: body memory, pair arithmetic, accumulators
// depends on ngf_pkg, ngf_mul and ngf_div
`default_nettype none

module ngf_datapath #(
    parameter int BODIES = 512
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  ngf_pkg::ctrl_cmd_t               cmd,
    output ngf_pkg::ctrl_stat_t              stat,
    input  wire                              in_user,
    input  wire  [ngf_pkg::IN_DATA_W-1:0]    in_data,
    input  wire                              cfg_valid,
    input  wire  [ngf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [ngf_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [ngf_pkg::OUT_DATA_W-1:0]   out_data,
    output logic                             out_user
);
    import ngf_pkg::*;

    localparam int unsigned ADDR_W = $clog2(BODIES);
    localparam int unsigned CNT_W  = $clog2(BODIES + 1);
    localparam int unsigned SQ_CNT_W = $clog2(ROOT_W + 1);

    // input fields
    logic [IDX_W-1:0]   in_idx;
    logic [COORD_W-1:0] in_x, in_y, in_z;
    logic [MASS_W-1:0]  in_mass;
    logic               in_idx_ok;

    assign in_idx    = in_data[8:0];
    assign in_x      = in_data[40:9];
    assign in_y      = in_data[72:41];
    assign in_z      = in_data[104:73];
    assign in_mass   = in_data[136:105];
    assign in_idx_ok = 32'(in_idx) < 32'(BODIES);

    // configuration registers
    logic [ACTIVE_W-1:0] active_reg;
    logic [GRAV_W-1:0]   grav_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
            grav_reg   <= GRAV_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ACTIVE_BODIES: active_reg <= cfg_data[ACTIVE_W-1:0];
                REG_GRAVITY:       grav_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // clearing pass address
    logic [ADDR_W-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // body memory, one word holds x, y, z and mass
    logic [MEM_W-1:0]  mem [BODIES];
    logic [MEM_W-1:0]  rdata_reg;
    logic [ADDR_W-1:0] tgt_addr_reg;
    logic [CNT_W-1:0]  j_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [MEM_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    assign mem_we    = cmd.clr_step | (cmd.load_wr & in_idx_ok);
    assign mem_waddr = cmd.clr_step ? clr_addr_reg : ADDR_W'(in_idx);
    assign mem_wdata = cmd.clr_step ? '0 : {in_mass, in_z, in_y, in_x};
    assign mem_raddr = cmd.rd_target ? tgt_addr_reg : j_reg[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_target | cmd.rd_body)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // read word fields
    logic signed [COORD_W-1:0] rd_pos [3];
    logic [MASS_W-1:0]         rd_mass;

    assign rd_pos[0] = rdata_reg[31:0];
    assign rd_pos[1] = rdata_reg[63:32];
    assign rd_pos[2] = rdata_reg[95:64];
    assign rd_mass   = rdata_reg[127:96];

    // shared arithmetic units
    logic [MA_W-1:0]   mul_a;
    logic [MB_W-1:0]   mul_b;
    logic [PROD_W-1:0] prod;
    logic              mul_busy, mul_done;
    logic [Q_W-1:0]    quo;
    logic              div_clip, div_done;

    // query and pair registers
    logic signed [COORD_W-1:0] pi_reg [3];
    logic [MASS_W-1:0]         mi_reg;
    logic [MASS_W-1:0]         mj_reg;
    logic signed [D_W-1:0]     d_reg [3];
    logic [1:0]                axis_reg;
    logic [R2_W-1:0]           r2_reg;
    logic [GMI_W-1:0]          gmi_reg;
    logic [DEN_W-1:0]          den_reg;
    logic [GM_W-1:0]           gm_reg;
    logic signed [ACC_W-1:0]   acc_reg [3];
    logic                      sat_reg;

    // distance on the current axis
    logic signed [D_W-1:0] d_axis;
    logic [D_W-1:0]        abs_axis;

    assign d_axis   = (axis_reg == 2'd0) ? d_reg[0] :
                      (axis_reg == 2'd1) ? d_reg[1] : d_reg[2];
    assign abs_axis = d_axis[D_W-1] ? D_W'(-d_axis) : D_W'(d_axis);

    // square root registers
    logic [RAD_W-1:0]    rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [SQ_CNT_W-1:0] sq_cnt_reg;
    logic                sq_busy_reg, sq_done_reg;
    logic [REM_W+1:0]    rem_sh;
    logic [REM_W+1:0]    trial;
    logic                sq_ge;

    // multiplier operand selection
    always_comb
    begin
        unique case (cmd.mul_op)
            MUL_GMI:
            begin
                mul_a = MA_W'(grav_reg);
                mul_b = MB_W'(mi_reg);
            end
            MUL_SQ:
            begin
                mul_a = MA_W'(abs_axis);
                mul_b = MB_W'(abs_axis);
            end
            MUL_RR:
            begin
                mul_a = MA_W'(root_reg);
                mul_b = root_reg;
            end
            MUL_RRR:
            begin
                mul_a = MA_W'(prod[2*ROOT_W-1:0]);
                mul_b = root_reg;
            end
            MUL_GM:
            begin
                mul_a = MA_W'(gmi_reg);
                mul_b = MB_W'(mj_reg);
            end
            MUL_NUM:
            begin
                mul_a = gm_reg;
                mul_b = MB_W'(abs_axis);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ngf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (prod),
        .busy  (mul_busy),
        .done  (mul_done)
    );

    ngf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   ({prod, 8'd0}),
        .den   (den_reg),
        .quo   (quo),
        .clip  (div_clip),
        .done  (div_done)
    );

    // query target, pair operands and walk index
    always_ff @(posedge clk)
    begin
        if (cmd.item_take)
        begin
            tgt_addr_reg <= ADDR_W'(in_idx);
        end
        if (cmd.latch_target)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pi_reg[k] <= rd_pos[k];
            end
            mi_reg <= rd_mass;
        end
        if (cmd.latch_gmi)
        begin
            gmi_reg <= prod[GMI_W-1:0];
            j_reg   <= '0;
        end
        else if (cmd.next_body)
        begin
            j_reg <= j_reg + 1'b1;
        end
        if (cmd.latch_body)
        begin
            for (int k = 0; k < 3; k++)
            begin
                d_reg[k] <= D_W'(rd_pos[k]) - D_W'(pi_reg[k]);
            end
            mj_reg <= rd_mass;
        end
        if (cmd.latch_den)
        begin
            den_reg <= prod[DEN_W-1:0];
        end
        if (cmd.latch_gm)
        begin
            gm_reg <= prod[GM_W-1:0];
        end
    end

    // axis counter and squared distance
    always_ff @(posedge clk)
    begin
        if (cmd.latch_body | cmd.latch_gm)
        begin
            axis_reg <= '0;
        end
        else if (cmd.r2_add | cmd.axis_skip | cmd.acc_add)
        begin
            axis_reg <= axis_reg + 1'b1;
        end
        if (cmd.latch_body)
        begin
            r2_reg <= '0;
        end
        else if (cmd.r2_add)
        begin
            r2_reg <= r2_reg + R2_W'(prod);
        end
    end

    // digit-by-digit square root, two radicand bits per cycle
    assign rem_sh = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign sq_ge  = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
            sq_done_reg <= 1'b0;
        end
        else
        begin
            sq_done_reg <= 1'b0;
            if (cmd.sqrt_start)
            begin
                sq_busy_reg <= 1'b1;
            end
            else if (sq_busy_reg && sq_cnt_reg == SQ_CNT_W'(1))
            begin
                sq_busy_reg <= 1'b0;
                sq_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            rad_reg    <= RAD_W'(r2_reg);
            rem_reg    <= '0;
            root_reg   <= '0;
            sq_cnt_reg <= SQ_CNT_W'(ROOT_W);
        end
        else if (sq_busy_reg)
        begin
            rad_reg    <= rad_reg << 2;
            sq_cnt_reg <= sq_cnt_reg - 1'b1;
            if (sq_ge)
            begin
                rem_reg  <= REM_W'(rem_sh - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_W'(rem_sh);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // force accumulators, term takes the sign of the distance
    logic signed [ACC_W-1:0] term;

    assign term = d_axis[D_W-1] ? -$signed(ACC_W'(quo)) : $signed(ACC_W'(quo));

    always_ff @(posedge clk)
    begin
        if (cmd.item_take)
        begin
            for (int k = 0; k < 3; k++)
            begin
                acc_reg[k] <= '0;
            end
            sat_reg <= 1'b0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg[axis_reg] <= acc_reg[axis_reg] + term;
            sat_reg           <= sat_reg | div_clip;
        end
    end

    // clipping to the output range
    logic [FORCE_W-1:0] force_clip [3];
    logic [2:0]         comp_sat;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            comp_sat[k]   = 1'b0;
            force_clip[k] = acc_reg[k][FORCE_W-1:0];
            if (acc_reg[k] > FORCE_MAX)
            begin
                force_clip[k] = FORCE_MAX[FORCE_W-1:0];
                comp_sat[k]   = 1'b1;
            end
            else if (acc_reg[k] < FORCE_MIN)
            begin
                force_clip[k] = FORCE_MIN[FORCE_W-1:0];
                comp_sat[k]   = 1'b1;
            end
        end
    end

    // output register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {force_clip[2], force_clip[1], force_clip[0]};
            out_user_reg <= sat_reg | (|comp_sat);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

    // active count limited to the table size
    logic [CNT_W-1:0] count;

    assign count = (32'(active_reg) > 32'(BODIES)) ? CNT_W'(BODIES) : CNT_W'(active_reg);

    // status to the controller
    always_comb
    begin
        stat.clr_last    = clr_addr_reg == ADDR_W'(BODIES - 1);
        stat.in_query    = item_cmd_t'(in_user) == CMD_QUERY;
        stat.in_idx_ok   = in_idx_ok;
        stat.body_more   = j_reg < count;
        stat.d_zero      = (d_reg[0] == '0) && (d_reg[1] == '0) && (d_reg[2] == '0);
        stat.axis_d_zero = d_axis == '0;
        stat.axis_last   = axis_reg == 2'd2;
        stat.mul_busy    = mul_busy;
        stat.mul_done    = mul_done;
        stat.sqrt_done   = sq_done_reg;
        stat.div_done    = div_done;
        stat.out_free    = !out_valid_reg || out_ready;
    end

endmodule

`default_nettype wire

### rtl/nbody_gravity_force_core.sv
// direct-sum gravity force: one query walks active bodies through a shared
// shift-add multiplier, a 2-bit-per-cycle square root and a bit-serial divider.
// a body at a distinct position runs the multiplications, 34 root steps and up to
// 51 divide steps per non-zero axis; a coincident body passes only the read, load
// and check states; loads are written to the table straight from idle.
// after reset a clearing pass zeroes the whole table, no input taken.
`default_nettype none

module nbody_gravity_force_core #(
    parameter int BODIES = 512
) (
    input  wire                                clk,
    input  wire                                rst_n,
    // transfer in: tdata = body_index, pos_x, pos_y, pos_z, body_mass, zero pad
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [ngf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  wire                                s_axis_tuser,   // cmd
    // transfer out: tdata = force_x, force_y, force_z
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [ngf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tuser,   // saturated
    // register writes
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [ngf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [ngf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ngf_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    assign cfg_ready = 1'b1;

    ngf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ngf_datapath #(
        .BODIES (BODIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_user   (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

    // no input transfer during the clearing pass
    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !s_axis_tready)
        else $error("input taken during clearing pass");

    // shared multiplier never restarted while working
    a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |-> !stat.mul_busy)
        else $error("multiplier started while busy");

    // a result only appears after the final stage loads it
    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.out_load))
        else $error("result shown without load");

endmodule

`default_nettype wire

### dv/tb_top.sv
// self-checking testbench for nbody_gravity_force_core: loads bodies, queries forces
// and compares each result with an in-bench force predictor; needs ngf_pkg and the core
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ngf_pkg::*;

    localparam int BODIES = 512;
    localparam longint LIMIT_CYCLES = 20000000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [159:0] TERM_CAP = 160'd1 << 50;

    typedef struct packed {
        logic [FORCE_W-1:0] fx;
        logic [FORCE_W-1:0] fy;
        logic [FORCE_W-1:0] fz;
        logic               sat;
    } force_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    logic [COORD_W-1:0] x_mem [BODIES];
    logic [COORD_W-1:0] y_mem [BODIES];
    logic [COORD_W-1:0] z_mem [BODIES];
    logic [MASS_W-1:0]  m_mem [BODIES];
    logic [ACTIVE_W-1:0] active_cnt;
    logic [GRAV_W-1:0]   grav;

    force_t pending_forces[$];
    int     err_count = 0;
    int     forces_seen = 0;
    int     sat_seen = 0;
    int     items_sent = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_left = 0;
    longint cycle_count = 0;

    nbody_gravity_force_core #(.BODIES(BODIES)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // body_index, pos_x, pos_y, pos_z, body_mass
        .s_axis_tuser  (s_axis_tuser),   // cmd
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // force_x, force_y, force_z
        .m_axis_tuser  (m_axis_tuser),   // saturated
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: random stalls plus a counted hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        err_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        force_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            forces_seen++;
            if (m_axis_tuser)
                sat_seen++;
            if (pending_forces.size() == 0)
                report("unexpected result", 64'(m_axis_tdata[47:0]), 64'd0);
            else
            begin
                want = pending_forces.pop_front();
                if (m_axis_tdata[47:0] !== want.fx)
                    report("force_x", 64'(m_axis_tdata[47:0]), 64'(want.fx));
                if (m_axis_tdata[95:48] !== want.fy)
                    report("force_y", 64'(m_axis_tdata[95:48]), 64'(want.fy));
                if (m_axis_tdata[143:96] !== want.fz)
                    report("force_z", 64'(m_axis_tdata[143:96]), 64'(want.fz));
                if (m_axis_tuser !== want.sat)
                    report("saturated", 64'(m_axis_tuser), 64'(want.sat));
            end
        end
    end

    function automatic logic [159:0] root_floor(input logic [159:0] v);
        logic [159:0] res;
        logic [159:0] cand;
        res = '0;
        for (int b = 33; b >= 0; b--)
        begin
            cand = res | (160'd1 << b);
            if (cand * cand <= v)
                res = cand;
        end
        return res;
    endfunction

    // direct-sum force on one target
    function automatic force_t calc_force(input logic [IDX_W-1:0] tgt);
        force_t f;
        longint acc [3];
        longint pi [3];
        longint d [3];
        longint lim;
        logic [159:0] r2, r, den, gm, num, q, mag;
        int cnt;
        logic sat;
        sat = 1'b0;
        acc = '{0, 0, 0};
        cnt = (active_cnt > BODIES) ? BODIES : int'(active_cnt);
        pi[0] = longint'($signed(x_mem[tgt]));
        pi[1] = longint'($signed(y_mem[tgt]));
        pi[2] = longint'($signed(z_mem[tgt]));
        for (int j = 0; j < cnt; j++)
        begin
            d[0] = longint'($signed(x_mem[j])) - pi[0];
            d[1] = longint'($signed(y_mem[j])) - pi[1];
            d[2] = longint'($signed(z_mem[j])) - pi[2];
            // coincident pair, target itself included, adds nothing
            if (d[0] == 0 && d[1] == 0 && d[2] == 0)
                continue;
            r2 = '0;
            for (int l = 0; l < 3; l++)
            begin
                mag = 160'(d[l] < 0 ? -d[l] : d[l]);
                r2 = r2 + mag * mag;
            end
            r = root_floor(r2);
            den = r * r * r;
            gm = 160'(grav) * 160'(m_mem[tgt]) * 160'(m_mem[j]);
            for (int l = 0; l < 3; l++)
            begin
                if (d[l] == 0)
                    continue;
                mag = 160'(d[l] < 0 ? -d[l] : d[l]);
                num = (gm * mag) << 8;
                q = num / den;
                // single pair term limit
                if (q > TERM_CAP)
                begin
                    q = TERM_CAP;
                    sat = 1'b1;
                end
                acc[l] += (d[l] < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
            end
        end
        lim = longint'(FORCE_MAX);
        for (int l = 0; l < 3; l++)
        begin
            if (acc[l] > lim)
            begin
                acc[l] = lim;
                sat = 1'b1;
            end
            if (acc[l] < -lim - 1)
            begin
                acc[l] = -lim - 1;
                sat = 1'b1;
            end
        end
        f.fx = acc[0][47:0];
        f.fy = acc[1][47:0];
        f.fz = acc[2][47:0];
        f.sat = sat;
        return f;
    endfunction

    task automatic send_item(input item_cmd_t cmd, input logic [IDX_W-1:0] idx,
                             input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input logic [31:0] mass);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'd0, mass, pz, py, px, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        if (cmd == CMD_LOAD)
        begin
            x_mem[idx] = px;
            y_mem[idx] = py;
            z_mem[idx] = pz;
            m_mem[idx] = mass;
        end
        else
            pending_forces.push_back(calc_force(idx));
    endtask

    task automatic load_body(input int idx, input int px, input int py, input int pz,
                             input logic [31:0] mass);
        send_item(CMD_LOAD, IDX_W'(idx), px, py, pz, mass);
    endtask

    task automatic query_body(input int idx);
        send_item(CMD_QUERY, IDX_W'(idx), $urandom, $urandom, $urandom, $urandom);
    endtask

    // wait until every result is in and the core has settled
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_forces.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_ACTIVE_BODIES)
            active_cnt = val[ACTIVE_W-1:0];
        else if (idx == REG_GRAVITY)
            grav = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // directed: extremes, register edges, coincident and saturating pairs
    task automatic test_directed();
        load_body(0, 32'sh0001_0000, 0, 0, 32'h0001_0000);
        load_body(1, -32'sh0002_0000, 32'sh0003_0000, -32'sh0001_0000, 32'h0004_0000);
        load_body(2, 0, 0, 0, 32'h0002_0000);           // coincident with unloaded entries
        load_body(511, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        query_body(0);                                  // full active range at reset value
        query_body(511);
        settle();
        write_reg(REG_ACTIVE_BODIES, 32'h0000_03FF);    // above table size, clamps
        query_body(1);
        settle();
        write_reg(REG_ACTIVE_BODIES, 32'd0);            // sums over nothing
        query_body(1);
        settle();
        write_reg(CFG_SPARE_A, 32'hFFFF_FFFF);          // unknown registers ignored
        write_reg(CFG_SPARE_B, 32'h0000_0001);
        write_reg(REG_ACTIVE_BODIES, 32'd4);
        write_reg(REG_GRAVITY, 32'hFFFF_FFFF);
        // adjacent heavy bodies: term and final clipping
        load_body(3, 32'h7FFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        query_body(3);
        query_body(511);                                // target outside active range
        settle();
        write_reg(REG_GRAVITY, 32'd0);
        query_body(1);
        settle();
        write_reg(REG_GRAVITY, 32'h0001_0000);
        write_reg(REG_ACTIVE_BODIES, 32'd1);
        query_body(0);
        settle();
    endtask

    task automatic random_body_load(input int span);
        int base;
        int idx;
        logic [31:0] mass;
        idx = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(span - 1);
        mass = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0004_0000);
        if ($urandom_range(9) < 6)
        begin
            // cluster near a common point so forces are significant
            base = $urandom_range(3) == 0 ? int'($urandom) : 0;
            load_body(idx, base + int'($urandom_range(2048)) - 1024,
                      base + int'($urandom_range(2048)) - 1024,
                      base + int'($urandom_range(2048)) - 1024, mass);
        end
        else
            load_body(idx, $urandom, $urandom, $urandom, mass);
    endtask

    // one randomised phase at given stall rates, several register settings
    task automatic test_random_phase(input int n, input int s_pct, input int r_pct);
        int active;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int seg = 0; seg < 6; seg++)
        begin
            active = $urandom_range(1, 6);
            write_reg(REG_ACTIVE_BODIES, active);
            case ($urandom_range(3))
                0:       write_reg(REG_GRAVITY, 32'hFFFF_FFFF);
                1:       write_reg(REG_GRAVITY, $urandom_range(1));
                default: write_reg(REG_GRAVITY, $urandom);
            endcase
            for (int k = 0; k < n / 6; k++)
            begin
                if ($urandom_range(9) < 7)
                    random_body_load(active + 1);
                else
                    query_body($urandom_range(15) == 0 ? $urandom_range(511)
                                                       : $urandom_range(active));
            end
            settle();
        end
    endtask

    // receiver held off while queries keep coming
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_ACTIVE_BODIES, 32'd2);
        hold_left = 3000;
        for (int k = 0; k < 8; k++)
            query_body(k % 3);
        settle();
    endtask

    initial
    begin
        for (int i = 0; i < BODIES; i++)
        begin
            x_mem[i] = '0;
            y_mem[i] = '0;
            z_mem[i] = '0;
            m_mem[i] = '0;
        end
        active_cnt = ACTIVE_RESET;
        grav = GRAV_RESET;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_phase(384, 6, 48);
        test_random_phase(384, 48, 6);
        test_random_phase(384, 0, 0);
        test_backpressure();
        $display("sent %0d items, checked %0d force results (%0d saturated)",
                 items_sent, forces_seen, sat_seen);
        $display("covered register extremes, coincident bodies, clipping and output stall");
        if (err_count == 0 && pending_forces.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
